FILE: sv/stb_pkg.sv
// Shared types and constants for the software timer bank.
`timescale 1ns / 1ps
package stb_pkg;

  localparam int NUM_TIMERS  = 4;
  localparam int COUNT_WIDTH = 32;
  localparam int ID_W        = 8;
  localparam int PERIOD_W    = 32;
  localparam int MASK_W      = 4;
  localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  typedef enum logic [2:0] {
    REQ_TICK       = 3'd0,
    REQ_START_ONE  = 3'd1,
    REQ_START_AUTO = 3'd2,
    REQ_STOP       = 3'd3,
    REQ_CHECK      = 3'd4
  } req_t;

  typedef struct packed {
    logic [2:0]          req_type;
    logic [ID_W-1:0]     timer_id;
    logic [PERIOD_W-1:0] period;
  } in_beat_t;

  typedef struct packed {
    logic [MASK_W-1:0] expired_mask;
    logic              fired;
    logic              bad_id;
  } out_beat_t;

  typedef struct packed {
    logic                   vld;
    req_t                   req;
    logic [ID_W-1:0]        id;
    logic [COUNT_WIDTH-1:0] per;
    logic [MASK_W-1:0]      mask;
    logic                   fired;
    logic                   bad;
  } stb_msg_t;

endpackage

FILE: sv/software_timer_bank.sv
// Top level of the software timer bank: a chain of timer cells.
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one request beat:
//   tick, start one-shot, start auto-reload, stop, or check-and-clear.
//   Output channel (out_valid/out_stall/out_data) returns exactly one beat
//   per request: expired mask on tick, fired flag on check, bad_id for a
//   command naming a timer at or above NUM_TIMERS.
//   A request passes through the chain of NUM_TIMERS cells, one register
//   per cell, before its result is loaded into the output register. One
//   request is in flight at a time; the next is taken the cycle after the
//   previous result lands in the output register.
//   in_stall is high while a request is in the chain or held.
//   When the receiver stalls, the finished result waits in the output
//   register; a following result waits in a holding register and blocks
//   new requests until it moves out.
//   Reset clears all counts, reload values, modes and flags, and empties
//   the chain and the output.
`timescale 1ns / 1ps
module software_timer_bank
  import stb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  stb_msg_t  chain [NUM_TIMERS+1];
  stb_msg_t  last;
  logic      accept;
  logic      done;
  logic      can_ld;
  logic      cmd;
  out_beat_t res;
  logic      busy_r, busy_nxt;
  logic      out_vld_r, out_vld_nxt;
  out_beat_t out_r, out_nxt;
  logic      pend_vld_r, pend_vld_nxt;
  out_beat_t pend_r, pend_nxt;

  assign accept = in_valid && !in_stall;
  assign cmd    = (in_data.req_type >= REQ_START_ONE) && (in_data.req_type <= REQ_CHECK);

  assign chain[0] = '{
    vld:   accept,
    req:   req_t'(in_data.req_type),
    id:    in_data.timer_id,
    per:   COUNT_WIDTH'(in_data.period),
    mask:  '0,
    fired: 1'b0,
    bad:   cmd && (in_data.timer_id >= ID_W'(NUM_TIMERS))
  };

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    stb_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .msg_i    (chain[i]),
      .msg_o    (chain[i+1])
    );
  end

  assign last   = chain[NUM_TIMERS];
  assign done   = last.vld;
  assign can_ld = !out_vld_r || !out_stall;

  always_comb begin
    res.expired_mask = last.mask;
    res.fired        = last.fired;
    res.bad_id       = last.bad;
  end

  always_comb begin
    busy_nxt     = busy_r;
    out_vld_nxt  = out_vld_r;
    out_nxt      = out_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
    if (done) begin
      if (can_ld) begin
        out_nxt     = res;
        out_vld_nxt = 1'b1;
        busy_nxt    = 1'b0;
      end else begin
        pend_nxt     = res;
        pend_vld_nxt = 1'b1;
      end
    end else if (pend_vld_r && can_ld) begin
      out_nxt      = pend_r;
      out_vld_nxt  = 1'b1;
      pend_vld_nxt = 1'b0;
      busy_nxt     = 1'b0;
    end
    if (accept) begin
      busy_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      busy_r     <= busy_nxt;
      out_vld_r  <= out_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign in_stall  = busy_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> busy_r)
    else $error("chain result without a request in flight");

  a_pend_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> out_vld_r)
    else $error("held result while output register is empty");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##NUM_TIMERS done)
    else $error("request did not leave the chain in time");

  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (done && last.bad) |-> (last.mask == '0 && !last.fired))
    else $error("bad id beat carries timer results");
`endif

endmodule

FILE: sv/stb_cell.sv
// One timer cell: holds one timer's state and forwards the command beat.
`timescale 1ns / 1ps
module stb_cell
  import stb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] cell_idx,
  input  stb_msg_t         msg_i,
  output stb_msg_t         msg_o
);

  logic [COUNT_WIDTH-1:0] rem_r, rem_nxt;
  logic [COUNT_WIDTH-1:0] rel_r, rel_nxt;
  logic                   auto_r, auto_nxt;
  logic                   flag_r, flag_nxt;
  stb_msg_t               msg_r, msg_nxt;
  logic [ID_W-1:0]        idx8;
  logic [COUNT_WIDTH-1:0] dec;
  logic                   hit;

  assign idx8 = ID_W'(cell_idx);
  assign dec  = rem_r - COUNT_WIDTH'(1);
  assign hit  = msg_i.vld && (msg_i.id == idx8);

  always_comb begin
    rem_nxt  = rem_r;
    rel_nxt  = rel_r;
    auto_nxt = auto_r;
    flag_nxt = flag_r;
    msg_nxt  = msg_i;
    if (msg_i.vld) begin
      case (msg_i.req)
        REQ_TICK: begin
          if (rem_r != '0) begin
            rem_nxt = dec;
            if (dec == '0) begin
              flag_nxt = 1'b1;
              if (auto_r) begin
                rem_nxt = rel_r;
              end
              for (int j = 0; j < MASK_W; j++) begin
                if (idx8 == ID_W'(j)) begin
                  msg_nxt.mask[j] = 1'b1;
                end
              end
            end
          end
        end
        REQ_START_ONE, REQ_START_AUTO: begin
          if (hit) begin
            rem_nxt  = msg_i.per;
            rel_nxt  = msg_i.per;
            flag_nxt = 1'b0;
            auto_nxt = (msg_i.req == REQ_START_AUTO);
          end
        end
        REQ_STOP: begin
          if (hit) begin
            rem_nxt  = '0;
            flag_nxt = 1'b0;
            auto_nxt = 1'b0;
          end
        end
        REQ_CHECK: begin
          if (hit) begin
            msg_nxt.fired = flag_r;
            flag_nxt      = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      rel_r  <= '0;
      auto_r <= 1'b0;
      flag_r <= 1'b0;
      msg_r  <= '0;
    end else begin
      rem_r  <= rem_nxt;
      rel_r  <= rel_nxt;
      auto_r <= auto_nxt;
      flag_r <= flag_nxt;
      msg_r  <= msg_nxt;
    end
  end

  assign msg_o = msg_r;

endmodule

FILE: bench/tb_top.sv
// Testbench for the software timer bank: directed table plus random requests, checked beat by beat.
`timescale 1ns / 1ps
module tb_top;
  import stb_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 6;
  localparam int RANDOM_ITEMS    = 1728;
  localparam int CALM_ITEM_FIRST = 700;
  localparam int CALM_ITEM_LAST  = 1000;
  localparam int HOLD_START      = 2500;
  localparam int HOLD_CYCLES     = 240;
  localparam int CALM_CYC_FIRST  = 5000;
  localparam int CALM_CYC_LAST   = 6500;
  localparam int IDLE_PCT        = 6;
  localparam int STALL_LIMIT     = 3000;
  localparam int DRAIN_CYCLES    = 4 * (NUM_TIMERS + 1);
  localparam int REPORT_MAX      = 10;
  localparam int N_DIRECTED      = 23;

  localparam logic [2:0] REQ_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;
  localparam logic [ID_W-1:0]     ID_MAX  = '1;
  localparam logic [PERIOD_W-1:0] PER_MAX = '1;

  localparam out_beat_t NO_EVENT    = '0;
  localparam out_beat_t BAD_ID_ONLY = '{expired_mask: '0, fired: 1'b0, bad_id: 1'b1};

  typedef struct packed {
    logic      typed;
    in_beat_t  beat;
    out_beat_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  logic [COUNT_WIDTH-1:0] timer_count  [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] timer_reload [NUM_TIMERS];
  logic                   timer_auto   [NUM_TIMERS];
  logic                   timer_flag   [NUM_TIMERS];

  out_beat_t   pending_results[$];
  int unsigned check_failures = 0;

  dir_row_t directed_rows [N_DIRECTED] = '{
    '{1'b1, '{REQ_CHECK,      8'd0,   32'd0},    NO_EVENT},
    '{1'b1, '{REQ_TICK,       8'd0,   32'd0},    NO_EVENT},
    '{1'b1, '{REQ_START_ONE,  8'd0,   32'd2},    NO_EVENT},
    '{1'b1, '{REQ_START_AUTO, 8'd1,   32'd1},    NO_EVENT},
    '{1'b1, '{REQ_START_ONE,  8'd2,   32'd0},    NO_EVENT},
    '{1'b1, '{REQ_START_AUTO, 8'd3,   PER_MAX},  NO_EVENT},
    '{1'b0, '{REQ_TICK,       ID_MAX, PER_MAX},  NO_EVENT},
    '{1'b0, '{REQ_TICK,       8'd0,   32'd0},    NO_EVENT},
    '{1'b0, '{REQ_CHECK,      8'd0,   32'd0},    NO_EVENT},
    '{1'b0, '{REQ_CHECK,      8'd0,   PER_MAX},  NO_EVENT},
    '{1'b0, '{REQ_CHECK,      8'd2,   32'd0},    NO_EVENT},
    '{1'b0, '{REQ_CHECK,      8'd1,   32'd0},    NO_EVENT},
    '{1'b1, '{REQ_STOP,       8'd1,   PER_MAX},  NO_EVENT},
    '{1'b0, '{REQ_TICK,       8'd0,   32'd0},    NO_EVENT},
    '{1'b0, '{REQ_CHECK,      8'd1,   32'd0},    NO_EVENT},
    '{1'b1, '{REQ_START_ONE,  8'd4,   32'd5},    BAD_ID_ONLY},
    '{1'b1, '{REQ_STOP,       ID_MAX, 32'd0},    BAD_ID_ONLY},
    '{1'b1, '{REQ_CHECK,      8'h80,  32'd0},    BAD_ID_ONLY},
    '{1'b1, '{REQ_START_AUTO, ID_MAX, PER_MAX},  BAD_ID_ONLY},
    '{1'b1, '{REQ_UNKNOWN_LO, 8'd0,   32'd0},    NO_EVENT},
    '{1'b1, '{REQ_UNKNOWN_HI, ID_MAX, PER_MAX},  NO_EVENT},
    '{1'b1, '{REQ_STOP,       8'd3,   32'd0},    NO_EVENT},
    '{1'b0, '{REQ_TICK,       8'd0,   32'd0},    NO_EVENT}
  };

  software_timer_bank u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      timer_count[i]  = '0;
      timer_reload[i] = '0;
      timer_auto[i]   = 1'b0;
      timer_flag[i]   = 1'b0;
    end
  end

  function automatic out_beat_t apply_request(input in_beat_t b);
    out_beat_t              r;
    logic [COUNT_WIDTH-1:0] per;
    int                     idx;
    r   = NO_EVENT;
    per = b.period[COUNT_WIDTH-1:0];
    idx = int'(b.timer_id);
    if (b.req_type == REQ_TICK) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (timer_count[i] != '0) begin
          timer_count[i] = timer_count[i] - 1'b1;
          if (timer_count[i] == '0) begin
            timer_flag[i] = 1'b1;
            if (timer_auto[i]) timer_count[i] = timer_reload[i];
            if (i < MASK_W) r.expired_mask[i] = 1'b1;
          end
        end
      end
    end else if (b.req_type <= REQ_CHECK) begin
      if (idx >= NUM_TIMERS) begin
        r.bad_id = 1'b1;
      end else begin
        case (b.req_type)
          REQ_START_ONE, REQ_START_AUTO: begin
            timer_count[idx]  = per;
            timer_reload[idx] = per;
            timer_flag[idx]   = 1'b0;
            timer_auto[idx]   = (b.req_type == REQ_START_AUTO);
          end
          REQ_STOP: begin
            timer_count[idx] = '0;
            timer_flag[idx]  = 1'b0;
            timer_auto[idx]  = 1'b0;
          end
          default: begin
            r.fired         = timer_flag[idx];
            timer_flag[idx] = 1'b0;
          end
        endcase
      end
    end
    return r;
  endfunction

  function automatic logic [PERIOD_W-1:0] random_period();
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 10) return PERIOD_W'($urandom);
    if (pick < 30) return PERIOD_W'($urandom_range(255, 0));
    return PERIOD_W'($urandom_range(8, 0));
  endfunction

  function automatic in_beat_t random_request();
    in_beat_t    b;
    int unsigned pick;
    pick       = $urandom_range(99, 0);
    b.timer_id = ID_W'($urandom_range(NUM_TIMERS - 1, 0));
    b.period   = PERIOD_W'($urandom);
    if (pick < 35) begin
      b.req_type = REQ_TICK;
      b.timer_id = ID_W'($urandom);
    end else if (pick < 55) begin
      b.req_type = REQ_START_ONE;
      b.period   = random_period();
    end else if (pick < 65) begin
      b.req_type = REQ_START_AUTO;
      b.period   = random_period();
    end else if (pick < 72) begin
      b.req_type = REQ_STOP;
    end else if (pick < 91) begin
      b.req_type = REQ_CHECK;
    end else if (pick < 96) begin
      b.req_type = 3'($urandom_range(int'(REQ_CHECK), int'(REQ_START_ONE)));
      b.timer_id = ID_W'($urandom_range(int'(ID_MAX), NUM_TIMERS));
    end else begin
      b.req_type = 3'($urandom_range(int'(REQ_UNKNOWN_HI), int'(REQ_UNKNOWN_LO)));
      b.timer_id = ID_W'($urandom);
    end
    return b;
  endfunction

  task automatic send_request(input in_beat_t b, input logic typed, input out_beat_t want,
                              input bit calm);
    out_beat_t predicted;
    while (!calm && $urandom_range(99, 0) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_request(b);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  initial begin : stimulus
    in_beat_t req;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed_rows[r])
      send_request(directed_rows[r].beat, directed_rows[r].typed, directed_rows[r].want, 1'b0);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      req = random_request();
      send_request(req, 1'b0, NO_EVENT, n >= CALM_ITEM_FIRST && n < CALM_ITEM_LAST);
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (check_failures == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin : receiver
    int unsigned cyc;
    cyc = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) out_stall <= 1'b1;
      else if (cyc >= CALM_CYC_FIRST && cyc < CALM_CYC_LAST) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(99, 0) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        if (check_failures < REPORT_MAX)
          $display("%0t: unexpected result beat mask=%h fired=%b bad_id=%b", $realtime,
                   out_data.expired_mask, out_data.fired, out_data.bad_id);
        check_failures++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.expired_mask !== want.expired_mask || out_data.fired !== want.fired ||
            out_data.bad_id !== want.bad_id) begin
          if (check_failures < REPORT_MAX)
            $display("%0t: result mismatch exp mask=%h fired=%b bad_id=%b got mask=%h fired=%b bad_id=%b",
                     $realtime, want.expired_mask, want.fired, want.bad_id,
                     out_data.expired_mask, out_data.fired, out_data.bad_id);
          check_failures++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

endmodule
